### sv/nal_packet_keyframe_classifier_top_defines.svh
// Assertion helpers used by the top-level file to check the block.
`ifndef NAL_PACKET_KEYFRAME_CLASSIFIER_TOP_DEFINES_SVH
`define NAL_PACKET_KEYFRAME_CLASSIFIER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while in reset.
`define NKC_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while in reset.
`define NKC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/nkc_pkg.sv
package nkc_pkg;

    localparam int BYTE_W      = 8;
    localparam int ACC_W       = 32;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 3;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_CODEC_IS_HEVC       = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LENGTH_PREFIX_BYTES = 1'd1;

    localparam logic [2:0] PREFIX_ANNEX_B = 3'd0;
    localparam logic [2:0] PREFIX_1       = 3'd1;
    localparam logic [2:0] PREFIX_2       = 3'd2;
    localparam logic [2:0] PREFIX_4       = 3'd4;

    localparam logic [4:0] H264_IDR        = 5'd5;
    localparam logic [4:0] H264_SLICE_MIN  = 5'd1;
    localparam logic [4:0] H264_SLICE_MAX  = 5'd4;
    localparam logic [5:0] HEVC_IDR_W_RADL = 6'd19;
    localparam logic [5:0] HEVC_IDR_N_LP   = 6'd20;
    localparam logic [5:0] HEVC_VCL_MAX    = 6'd15;
    localparam logic [5:0] HEVC_RSV_MAX    = 6'd31;

    typedef enum logic [1:0] {
        CLASS_NONKEY = 2'd0,
        CLASS_KEY    = 2'd1,
        CLASS_ERROR  = 2'd2
    } class_t;

    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_PLAIN = 2'd1,
        KIND_KEY   = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        U_NONE  = 2'd0,
        U_PLAIN = 2'd1,
        U_KEY   = 2'd2,
        U_ERR   = 2'd3
    } unit_res_t;

    typedef enum logic [1:0] {
        PH_PREFIX = 2'b01,
        PH_UNIT   = 2'b10
    } phase_t;

    typedef struct packed {
        kind_t kind;
        logic  err;
    } tally_t;

    typedef struct packed {
        logic   push;
        class_t cls;
    } q_push_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // Classifies one NAL unit from its length class and its two header bytes.
    function automatic unit_res_t nkc_unit_kind(
        input logic       hevc,
        input logic       len_zero,
        input logic       len_one,
        input logic [7:0] b0,
        input logic [7:0] b1
    );
        unit_res_t  res;
        logic [4:0] t264;
        logic [5:0] t265;
        t264 = b0[4:0];
        t265 = b0[6:1];
        res  = U_NONE;
        if (len_zero || b0[7]) begin
            res = U_ERR;
        end else if (!hevc) begin
            if (t264 == H264_IDR) begin
                res = U_KEY;
            end else if (t264 inside {[H264_SLICE_MIN:H264_SLICE_MAX]}) begin
                res = U_PLAIN;
            end
        end else if (len_one || b1[2:0] == 3'd0) begin
            // HEVC needs both header bytes and a nonzero temporal id.
            res = U_ERR;
        end else if (t265 == HEVC_IDR_W_RADL || t265 == HEVC_IDR_N_LP) begin
            res = U_KEY;
        end else if (t265 <= HEVC_VCL_MAX) begin
            res = U_PLAIN;
        end else if (t265 <= HEVC_RSV_MAX) begin
            res = U_ERR;
        end
        return res;
    endfunction

    // Folds one unit's class into the packet tally; mixing key and non-key is an error.
    function automatic tally_t nkc_note(input tally_t t, input unit_res_t r);
        tally_t o;
        kind_t  rk;
        o  = t;
        rk = (r == U_KEY) ? KIND_KEY : KIND_PLAIN;
        if (r == U_ERR) begin
            o.err = 1'b1;
        end else if (r != U_NONE) begin
            if (t.kind != KIND_NONE && t.kind != rk) begin
                o.err = 1'b1;
            end else begin
                o.kind = rk;
            end
        end
        return o;
    endfunction

endpackage

### sv/nal_packet_keyframe_classifier_top.sv
// Packet keyframe classifier.
// The input channel (in_valid/in_ready) takes one packet byte per request, with
// last_byte set on the final byte of a packet. The output channel
// (out_valid/out_ready) gives one packet_class per packet: 0 non-key, 1 key,
// 2 malformed or unclassifiable.
// Throughput is one byte per cycle while in_ready is high: the parser updates
// its state for a byte in the cycle it is accepted. The class is known when the
// last byte is accepted; it is registered into a two-entry result queue and
// from there moves into the output register, which drives out_valid.
// When the receiver stalls, results collect in the queue and the output
// register. Bytes that are not the last of a packet are still accepted; a last
// byte is held off while the queue is full.
// The configuration port (cfg_write, cfg_index, cfg_data) sets codec_is_hevc
// (index 0) and length_prefix_bytes (index 1). Any write also discards a
// partial packet.
// Reset selects H.264 with Annex B start codes and clears the parser, the queue
// and the output register.
`include "nal_packet_keyframe_classifier_top_defines.svh"

module nal_packet_keyframe_classifier_top
    import nkc_pkg::*;
#(
    parameter int LENGTH_WIDTH = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [7:0]             packet_byte,
    input  logic                   last_byte,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [1:0]             packet_class
);

    q_push_t   q_push;
    q_status_t q_status;
    class_t    q_head;
    logic      back_pop;
    logic      last_into_idle;

    // A finished packet with nothing ahead of it should move straight to the output.
    assign last_into_idle = in_valid && in_ready && last_byte && q_status.empty && !out_valid;

    nkc_front #(
        .LENGTH_WIDTH(LENGTH_WIDTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .packet_byte (packet_byte),
        .last_byte   (last_byte),
        .q_status    (q_status),
        .q_push      (q_push)
    );

    nkc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_push   (q_push),
        .pop      (back_pop),
        .q_status (q_status),
        .head     (q_head)
    );

    nkc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_status     (q_status),
        .head         (q_head),
        .pop          (back_pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .packet_class (packet_class)
    );

    `NKC_ASSERT_IMPL(a_no_push_when_full, q_status.full, !q_push.push, "push into a full queue")
    `NKC_ASSERT_IMPL(a_pop_needs_entry, back_pop, !q_status.empty, "pop from an empty queue")
    `NKC_ASSERT_NEXT(a_last_reaches_back, last_into_idle, back_pop, "result skipped the output")

endmodule

### sv/nkc_front.sv
module nkc_front
    import nkc_pkg::*;
#(
    parameter int LENGTH_WIDTH = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [BYTE_W-1:0]      packet_byte,
    input  logic                   last_byte,
    input  q_status_t              q_status,
    output q_push_t                q_push
);

    logic                    hevc_reg;
    logic [2:0]              mode_reg;
    phase_t                  phase_reg, phase_next;
    logic [1:0]              fill_reg, fill_next;
    logic [ACC_W-1:0]        acc_reg, acc_next;
    logic [2:0]              pcount_reg, pcount_next;
    logic [LENGTH_WIDTH-1:0] left_reg, left_next;
    logic [2:0]              span_reg, span_next;
    logic [1:0]              hcnt_reg, hcnt_next;
    logic [7:0]              hdr0_reg, hdr0_next;
    logic [7:0]              hdr1_reg, hdr1_next;
    kind_t                   kind_reg, kind_next;
    logic                    err_reg, err_next;
    logic                    accept;

    // A last byte waits for room in the queue; other bytes always go in.
    assign in_ready = !q_status.full || !last_byte;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        tally_t                  tally;
        logic [2:0]              zeros;
        logic [2:0]              pc_inc;
        logic [ACC_W-1:0]        acc_shift;
        logic [LENGTH_WIDTH-1:0] left_dec;
        logic                    start_code;

        phase_next  = phase_reg;
        fill_next   = fill_reg;
        acc_next    = acc_reg;
        pcount_next = pcount_reg;
        left_next   = left_reg;
        span_next   = span_reg;
        hcnt_next   = hcnt_reg;
        hdr0_next   = hdr0_reg;
        hdr1_next   = hdr1_reg;
        tally.kind  = kind_reg;
        tally.err   = err_reg;
        zeros       = 3'd2;
        pc_inc      = pcount_reg + 3'd1;
        acc_shift   = {acc_reg[ACC_W-BYTE_W-1:0], packet_byte};
        left_dec    = left_reg - LENGTH_WIDTH'(1);
        start_code  = (packet_byte == 8'h01) && (fill_reg >= 2'd2);
        q_push.push = 1'b0;
        q_push.cls  = CLASS_ERROR;

        if (accept && !err_reg) begin
            case (mode_reg)
                PREFIX_ANNEX_B:
                begin
                    if (phase_reg == PH_PREFIX) begin
                        if (packet_byte == 8'h00) begin
                            if (fill_reg == 2'd3) begin
                                tally.err = 1'b1;
                            end else begin
                                fill_next = fill_reg + 2'd1;
                            end
                        end else if (start_code) begin
                            phase_next = PH_UNIT;
                            span_next  = 3'd0;
                            hcnt_next  = 2'd0;
                            fill_next  = 2'd0;
                        end else begin
                            tally.err = 1'b1;
                        end
                    end else if (start_code) begin
                        // The zeros of this start code were counted into the unit.
                        zeros = (fill_reg == 2'd3) ? 3'd3 : 3'd2;
                        tally = nkc_note(tally, nkc_unit_kind(hevc_reg,
                            span_reg == zeros, span_reg == zeros + 3'd1,
                            hdr0_reg, hdr1_reg));
                        span_next = 3'd0;
                        hcnt_next = 2'd0;
                        fill_next = 2'd0;
                    end else begin
                        if (hcnt_reg == 2'd0) begin
                            hdr0_next = packet_byte;
                        end else if (hcnt_reg == 2'd1) begin
                            hdr1_next = packet_byte;
                        end
                        if (hcnt_reg != 2'd2) begin
                            hcnt_next = hcnt_reg + 2'd1;
                        end
                        // The span saturates; beyond seven bytes only "long" matters.
                        if (span_reg != 3'd7) begin
                            span_next = span_reg + 3'd1;
                        end
                        if (packet_byte == 8'h00) begin
                            if (fill_reg != 2'd3) begin
                                fill_next = fill_reg + 2'd1;
                            end
                        end else begin
                            fill_next = 2'd0;
                        end
                    end
                end
                PREFIX_1, PREFIX_2, PREFIX_4:
                begin
                    if (phase_reg == PH_PREFIX) begin
                        acc_next    = acc_shift;
                        pcount_next = pc_inc;
                        if (pc_inc >= mode_reg) begin
                            if (acc_shift == '0 || (acc_shift >> LENGTH_WIDTH) != '0) begin
                                tally.err = 1'b1;
                            end else begin
                                left_next  = acc_shift[LENGTH_WIDTH-1:0];
                                hcnt_next  = 2'd0;
                                phase_next = PH_UNIT;
                            end
                        end
                    end else begin
                        if (hcnt_reg == 2'd0) begin
                            hdr0_next = packet_byte;
                        end else if (hcnt_reg == 2'd1) begin
                            hdr1_next = packet_byte;
                        end
                        if (hcnt_reg != 2'd2) begin
                            hcnt_next = hcnt_reg + 2'd1;
                        end
                        left_next = left_dec;
                        if (left_dec == '0) begin
                            tally = nkc_note(tally, nkc_unit_kind(hevc_reg,
                                hcnt_next == 2'd0, hcnt_next == 2'd1,
                                hdr0_next, hdr1_next));
                            phase_next  = PH_PREFIX;
                            pcount_next = 3'd0;
                            acc_next    = '0;
                        end
                    end
                end
                default:
                begin
                    tally.err = 1'b1;
                end
            endcase
        end

        if (accept && last_byte && !tally.err) begin
            if (mode_reg == PREFIX_ANNEX_B) begin
                if (phase_next == PH_PREFIX) begin
                    tally.err = 1'b1;
                end else begin
                    tally = nkc_note(tally, nkc_unit_kind(hevc_reg,
                        span_next == 3'd0, span_next == 3'd1, hdr0_next, hdr1_next));
                end
            end else if (phase_next != PH_PREFIX || pcount_next != 3'd0) begin
                tally.err = 1'b1;
            end
        end

        kind_next = tally.kind;
        err_next  = tally.err;

        if (accept && last_byte) begin
            q_push.push = 1'b1;
            if (tally.err || tally.kind == KIND_NONE) begin
                q_push.cls = CLASS_ERROR;
            end else if (tally.kind == KIND_KEY) begin
                q_push.cls = CLASS_KEY;
            end else begin
                q_push.cls = CLASS_NONKEY;
            end
            phase_next  = PH_PREFIX;
            fill_next   = 2'd0;
            acc_next    = '0;
            pcount_next = 3'd0;
            left_next   = '0;
            span_next   = 3'd0;
            hcnt_next   = 2'd0;
            hdr0_next   = 8'h00;
            hdr1_next   = 8'h00;
            kind_next   = KIND_NONE;
            err_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            hevc_reg   <= 1'b0;
            mode_reg   <= PREFIX_ANNEX_B;
            phase_reg  <= PH_PREFIX;
            fill_reg   <= 2'd0;
            acc_reg    <= '0;
            pcount_reg <= 3'd0;
            left_reg   <= '0;
            span_reg   <= 3'd0;
            hcnt_reg   <= 2'd0;
            hdr0_reg   <= 8'h00;
            hdr1_reg   <= 8'h00;
            kind_reg   <= KIND_NONE;
            err_reg    <= 1'b0;
        end else if (cfg_write) begin
            // A register write also drops any partial packet.
            case (cfg_index)
                CFG_CODEC_IS_HEVC:       hevc_reg <= cfg_data[0];
                CFG_LENGTH_PREFIX_BYTES: mode_reg <= cfg_data;
                default:                 ;
            endcase
            phase_reg  <= PH_PREFIX;
            fill_reg   <= 2'd0;
            acc_reg    <= '0;
            pcount_reg <= 3'd0;
            left_reg   <= '0;
            span_reg   <= 3'd0;
            hcnt_reg   <= 2'd0;
            hdr0_reg   <= 8'h00;
            hdr1_reg   <= 8'h00;
            kind_reg   <= KIND_NONE;
            err_reg    <= 1'b0;
        end else begin
            phase_reg  <= phase_next;
            fill_reg   <= fill_next;
            acc_reg    <= acc_next;
            pcount_reg <= pcount_next;
            left_reg   <= left_next;
            span_reg   <= span_next;
            hcnt_reg   <= hcnt_next;
            hdr0_reg   <= hdr0_next;
            hdr1_reg   <= hdr1_next;
            kind_reg   <= kind_next;
            err_reg    <= err_next;
        end
    end

endmodule

### sv/nkc_queue.sv
module nkc_queue
    import nkc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  q_push_t   q_push,
    input  logic      pop,
    output q_status_t q_status,
    output class_t    head
);

    class_t            slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign q_status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_status.empty = (count_reg == '0);
    assign head           = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = q_push.push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (q_push.push && !pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (pop && !q_push.push) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_push.push) begin
            slot_reg[wr_ptr_reg] <= q_push.cls;
        end
    end

endmodule

### sv/nkc_back.sv
module nkc_back
    import nkc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  q_status_t  q_status,
    input  class_t     head,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] packet_class
);

    logic   valid_reg, valid_next;
    class_t class_reg;

    // Take the next result whenever the output register is empty or being drained.
    assign pop          = !q_status.empty && (!valid_reg || out_ready);
    assign out_valid    = valid_reg;
    assign packet_class = class_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (pop) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop) begin
            class_reg <= head;
        end
    end

endmodule

### test/tb.sv
module tb;
    import nkc_pkg::*;

    localparam int LEN_W = 32;
    localparam int HOLD_CYCLES = 150;
    localparam int STALL_LIMIT = 2000;
    localparam logic [2:0] PREFIX_BAD = 3'd3;

    typedef enum int {UF_KEY, UF_PLAIN, UF_SKIP, UF_BAD} unit_flavor_t;

    class keyframe_scoreboard;
        bit          hevc;
        logic [2:0]  pfx_size;
        bit          in_unit;
        int unsigned zero_run;
        logic [63:0] len_acc;
        int unsigned pfx_seen;
        logic [31:0] unit_len;
        int unsigned hdr_seen;
        logic [7:0]  hdr0;
        logic [7:0]  hdr1;
        kind_t       seen;
        bit          bad;
        class_t      class_due[$];
        int          failures;
        int          n_key;
        int          n_plain;
        int          n_err;

        function new();
            hevc = 1'b0;
            pfx_size = PREFIX_ANNEX_B;
            failures = 0;
            n_key = 0;
            n_plain = 0;
            n_err = 0;
            clear_packet();
        endfunction

        function void clear_packet();
            in_unit = 1'b0;
            zero_run = 0;
            len_acc = '0;
            pfx_seen = 0;
            unit_len = '0;
            hdr_seen = 0;
            hdr0 = '0;
            hdr1 = '0;
            seen = KIND_NONE;
            bad = 1'b0;
        endfunction

        function void set_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [2:0] value);
            if (idx == CFG_CODEC_IS_HEVC)
            begin
                hevc = value[0];
            end
            else
            begin
                pfx_size = value;
            end
            clear_packet();
        endfunction

        function int pending();
            return class_due.size();
        endfunction

        // Merges one finished unit into the packet verdict.
        function void fold_unit(input logic [31:0] len);
            kind_t      k;
            logic [5:0] t;
            k = KIND_NONE;
            if (len == 0 || hdr0[7])
            begin
                bad = 1'b1;
                return;
            end
            if (!hevc)
            begin
                if (hdr0[4:0] == H264_IDR)
                begin
                    k = KIND_KEY;
                end
                else if (hdr0[4:0] >= H264_SLICE_MIN && hdr0[4:0] <= H264_SLICE_MAX)
                begin
                    k = KIND_PLAIN;
                end
            end
            else
            begin
                if (len < 2 || hdr1[2:0] == 3'd0)
                begin
                    bad = 1'b1;
                    return;
                end
                t = hdr0[6:1];
                if (t == HEVC_IDR_W_RADL || t == HEVC_IDR_N_LP)
                begin
                    k = KIND_KEY;
                end
                else if (t <= HEVC_VCL_MAX)
                begin
                    k = KIND_PLAIN;
                end
                else if (t <= HEVC_RSV_MAX)
                begin
                    bad = 1'b1;
                    return;
                end
            end
            if (k != KIND_NONE)
            begin
                if (seen != KIND_NONE && seen != k)
                begin
                    bad = 1'b1;
                end
                else
                begin
                    seen = k;
                end
            end
        endfunction

        function void open_unit();
            unit_len = '0;
            hdr_seen = 0;
            zero_run = 0;
        endfunction

        function void grab_header(input logic [7:0] b);
            if (hdr_seen == 0)
            begin
                hdr0 = b;
            end
            else if (hdr_seen == 1)
            begin
                hdr1 = b;
            end
            if (hdr_seen < 2)
            begin
                hdr_seen++;
            end
        endfunction

        function void annexb_byte(input logic [7:0] b);
            if (!in_unit)
            begin
                if (b == 8'h00)
                begin
                    if (zero_run >= 3)
                    begin
                        bad = 1'b1;
                    end
                    else
                    begin
                        zero_run++;
                    end
                end
                else if (b == 8'h01 && zero_run >= 2)
                begin
                    in_unit = 1'b1;
                    open_unit();
                end
                else
                begin
                    bad = 1'b1;
                end
                return;
            end
            // The zeros of a start code were counted into the unit before the 01 showed up.
            if (b == 8'h01 && zero_run >= 2)
            begin
                fold_unit(unit_len - ((zero_run >= 3) ? 32'd3 : 32'd2));
                open_unit();
                return;
            end
            grab_header(b);
            if (unit_len != '1)
            begin
                unit_len++;
            end
            if (b == 8'h00)
            begin
                if (zero_run < 3)
                begin
                    zero_run++;
                end
            end
            else
            begin
                zero_run = 0;
            end
        endfunction

        function void prefixed_byte(input logic [7:0] b);
            if (!in_unit)
            begin
                len_acc = ((len_acc << 8) | {56'd0, b}) & 64'h0000_0000_ffff_ffff;
                pfx_seen++;
                if (pfx_seen >= pfx_size)
                begin
                    if (len_acc == 0 || len_acc > ((64'd1 << LEN_W) - 64'd1))
                    begin
                        bad = 1'b1;
                        return;
                    end
                    unit_len = len_acc[31:0];
                    hdr_seen = 0;
                    in_unit = 1'b1;
                end
                return;
            end
            grab_header(b);
            unit_len--;
            if (unit_len == 0)
            begin
                fold_unit(hdr_seen);
                in_unit = 1'b0;
                pfx_seen = 0;
                len_acc = '0;
            end
        endfunction

        function void take_byte(input logic [7:0] b, input logic is_last);
            class_t c;
            if (!bad)
            begin
                if (pfx_size == PREFIX_ANNEX_B)
                begin
                    annexb_byte(b);
                end
                else if (pfx_size == PREFIX_1 || pfx_size == PREFIX_2 || pfx_size == PREFIX_4)
                begin
                    prefixed_byte(b);
                end
                else
                begin
                    bad = 1'b1;
                end
            end
            if (!is_last)
            begin
                return;
            end
            if (!bad)
            begin
                if (pfx_size == PREFIX_ANNEX_B)
                begin
                    if (!in_unit)
                    begin
                        bad = 1'b1;
                    end
                    else
                    begin
                        fold_unit(unit_len);
                    end
                end
                else if (in_unit || pfx_seen != 0)
                begin
                    bad = 1'b1;
                end
            end
            if (bad || seen == KIND_NONE)
            begin
                c = CLASS_ERROR;
            end
            else if (seen == KIND_KEY)
            begin
                c = CLASS_KEY;
            end
            else
            begin
                c = CLASS_NONKEY;
            end
            class_due.push_back(c);
            clear_packet();
        endfunction

        function void check_class(input logic [1:0] got);
            class_t want;
            if (class_due.size() == 0)
            begin
                $display("%0t: packet_class expected none, actual %0d", $time, got);
                failures++;
                return;
            end
            want = class_due.pop_front();
            if (got !== want)
            begin
                $display("%0t: packet_class mismatch, expected %0d, actual %0d",
                         $time, want, got);
                failures++;
            end
            if (want == CLASS_KEY)
            begin
                n_key++;
            end
            else if (want == CLASS_NONKEY)
            begin
                n_plain++;
            end
            else
            begin
                n_err++;
            end
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic [7:0]             packet_byte = 8'h00;
    logic                   last_byte = 1'b0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [1:0]             packet_class;

    keyframe_scoreboard sb = new();

    bit         calm = 1'b0;
    bit         stall_req = 1'b0;
    bit         cur_hevc = 1'b0;
    logic [2:0] cur_size = PREFIX_ANNEX_B;
    logic [7:0] frame[$];
    logic [7:0] unit_buf[$];
    int         bytes_sent = 0;
    int         quiet_cycles = 0;

    nal_packet_keyframe_classifier_top #(
        .LENGTH_WIDTH(LEN_W)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .packet_byte  (packet_byte),
        .last_byte    (last_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .packet_class (packet_class)
    );

    always #4 clk = ~clk;

    // Called at a falling edge; returns at the falling edge after the request is taken.
    task automatic send_byte(input logic [7:0] b, input logic is_last);
        if (!calm && $urandom_range(99) < 12)
        begin
            in_valid <= 1'b0;
            do @(negedge clk); while ($urandom_range(99) < 40);
        end
        in_valid <= 1'b1;
        packet_byte <= b;
        last_byte <= is_last;
        do @(posedge clk); while (!in_ready);
        sb.take_byte(b, is_last);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_frame();
        foreach (frame[i])
        begin
            send_byte(frame[i], i == frame.size() - 1);
        end
    endtask

    task automatic set_mode(input bit hevc, input logic [2:0] size);
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= CFG_CODEC_IS_HEVC;
        cfg_data <= CFG_DATA_W'(hevc);
        @(negedge clk);
        cfg_index <= CFG_LENGTH_PREFIX_BYTES;
        cfg_data <= size;
        @(negedge clk);
        cfg_write <= 1'b0;
        sb.set_reg(CFG_CODEC_IS_HEVC, {2'b00, hevc});
        sb.set_reg(CFG_LENGTH_PREFIX_BYTES, size);
        cur_hevc = hevc;
        cur_size = size;
    endtask

    function automatic void add_header(input unit_flavor_t f);
        logic [7:0] b0;
        logic [7:0] b1;
        logic [5:0] t;
        int         how;
        b0 = 8'($urandom);
        b1 = 8'($urandom);
        how = $urandom_range(3);
        if (!cur_hevc)
        begin
            b0[7] = 1'b0;
            case (f)
                UF_KEY:   b0[4:0] = H264_IDR;
                UF_PLAIN: b0[4:0] = 5'($urandom_range(H264_SLICE_MIN, H264_SLICE_MAX));
                UF_SKIP:  b0[4:0] = (how == 0) ? 5'd0 : 5'($urandom_range(6, 31));
                default:  b0[7] = 1'b1;
            endcase
            unit_buf.push_back(b0);
            return;
        end
        if (b1[2:0] == 3'd0)
        begin
            b1[2:0] = 3'($urandom_range(1, 7));
        end
        case (f)
            UF_KEY:   t = $urandom_range(1) ? HEVC_IDR_W_RADL : HEVC_IDR_N_LP;
            UF_PLAIN: t = 6'($urandom_range(0, HEVC_VCL_MAX));
            UF_SKIP:  t = 6'($urandom_range(32, 63));
            default:  t = $urandom_range(1) ? 6'($urandom_range(16, 18))
                                            : 6'($urandom_range(21, HEVC_RSV_MAX));
        endcase
        b0[7:1] = {1'b0, t};
        // A bad HEVC unit is a reserved type, a zero temporal id, the forbidden bit
        // or a header cut short after its first byte.
        if (f == UF_BAD && how == 1)
        begin
            b0[6:1] = HEVC_IDR_W_RADL;
            b1[2:0] = 3'd0;
        end
        else if (f == UF_BAD && how == 2)
        begin
            b0[7] = 1'b1;
        end
        unit_buf.push_back(b0);
        if (!(f == UF_BAD && how == 3))
        begin
            unit_buf.push_back(b1);
        end
    endfunction

    function automatic void emit_unit();
        int len;
        len = unit_buf.size();
        if (cur_size == PREFIX_ANNEX_B)
        begin
            if ($urandom_range(3) == 0)
            begin
                frame.push_back(8'h00);
            end
            frame.push_back(8'h00);
            frame.push_back(8'h00);
            frame.push_back(8'h01);
        end
        else
        begin
            for (int k = int'(cur_size) - 1; k >= 0; k--)
            begin
                frame.push_back(8'(len >> (8 * k)));
            end
        end
        foreach (unit_buf[i])
        begin
            frame.push_back(unit_buf[i]);
        end
        unit_buf.delete();
    endfunction

    // Mostly one kind of picture per packet, with parameter sets and the odd stray unit mixed in.
    function automatic void build_packet();
        unit_flavor_t main_f;
        unit_flavor_t f;
        int           r;
        frame.delete();
        main_f = $urandom_range(1) ? UF_KEY : UF_PLAIN;
        repeat ($urandom_range(1, 3))
        begin
            r = $urandom_range(99);
            f = main_f;
            if (r < 15)
            begin
                f = UF_SKIP;
            end
            else if (r < 19)
            begin
                f = (main_f == UF_KEY) ? UF_PLAIN : UF_KEY;
            end
            else if (r < 23)
            begin
                f = UF_BAD;
            end
            add_header(f);
            repeat ($urandom_range(0, 4))
            begin
                unit_buf.push_back(($urandom_range(9) == 0) ? 8'h00
                                                            : 8'($urandom_range(1, 255)));
            end
            emit_unit();
        end
    endfunction

    function automatic void break_packet();
        int sz;
        sz = (cur_size == PREFIX_ANNEX_B) ? 0 : int'(cur_size);
        case ($urandom_range(4))
            0:
            begin
                frame.delete();
                repeat ($urandom_range(1, 8)) frame.push_back(8'($urandom));
            end
            1:
            begin
                if (frame.size() > 1)
                begin
                    repeat ($urandom_range(1, frame.size() - 1)) void'(frame.pop_back());
                end
            end
            2:
            begin
                // A trailing start code, or a zero length prefix.
                if (sz == 0)
                begin
                    frame.push_back(8'h00);
                    frame.push_back(8'h00);
                    frame.push_back(8'h01);
                end
                else
                begin
                    repeat (sz) frame.push_back(8'h00);
                end
            end
            3:
            begin
                // An empty first unit, or a length far past the end of the packet.
                if (sz == 0)
                begin
                    frame.push_front(8'h01);
                    frame.push_front(8'h00);
                    frame.push_front(8'h00);
                end
                else
                begin
                    repeat (sz) frame.push_front(8'hff);
                end
            end
            default: frame.push_front(8'($urandom_range(1, 255)));
        endcase
    endfunction

    task automatic run_phase(input bit hevc, input logic [2:0] size, input bit quiet,
                             input bit squeeze, input int budget);
        int sent;
        set_mode(hevc, size);
        calm = quiet;
        stall_req = squeeze;
        sent = 0;
        while (sent < budget)
        begin
            build_packet();
            if ($urandom_range(99) < 20)
            begin
                break_packet();
            end
            send_frame();
            sent += frame.size();
        end
        calm = 1'b0;
    endtask

    task automatic run_directed();
        // H.264 with start codes, the setting after reset.
        frame = '{8'h00, 8'h00, 8'h01, 8'h65, 8'h88};
        send_frame();
        frame = '{8'h00, 8'h00, 8'h00, 8'h01, 8'h41, 8'h9a};
        send_frame();
        frame = '{8'h00, 8'h00, 8'h01, 8'h67, 8'h42, 8'h00, 8'h00, 8'h01, 8'h65};
        send_frame();
        frame = '{8'h00, 8'h00, 8'h01, 8'h06, 8'h05};
        send_frame();
        frame = '{8'h00, 8'h00, 8'h01, 8'he5};
        send_frame();
        frame = '{8'h00, 8'h00, 8'h01, 8'h65, 8'h00, 8'h00, 8'h01, 8'h41};
        send_frame();
        frame = '{8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h01, 8'h65};
        send_frame();
        frame = '{8'h00, 8'h00, 8'h01, 8'h65, 8'h00, 8'h00, 8'h01};
        send_frame();
        frame = '{8'h09, 8'h00, 8'h00, 8'h01, 8'h65};
        send_frame();
        frame = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h65};
        send_frame();
        frame = '{8'hff};
        send_frame();
        frame = '{8'h00, 8'h00, 8'h01};
        send_frame();

        set_mode(1'b1, PREFIX_ANNEX_B);
        frame = '{8'h00, 8'h00, 8'h01, 8'h26, 8'h01};
        send_frame();
        frame = '{8'h00, 8'h00, 8'h01, 8'h28, 8'h01};
        send_frame();
        frame = '{8'h00, 8'h00, 8'h01, 8'h02, 8'h01, 8'haf};
        send_frame();
        frame = '{8'h00, 8'h00, 8'h01, 8'h40, 8'h01};
        send_frame();
        frame = '{8'h00, 8'h00, 8'h01, 8'h22, 8'h01};
        send_frame();
        frame = '{8'h00, 8'h00, 8'h01, 8'h2a, 8'h01};
        send_frame();
        frame = '{8'h00, 8'h00, 8'h01, 8'h26, 8'h00};
        send_frame();
        frame = '{8'h00, 8'h00, 8'h01, 8'h26};
        send_frame();
        frame = '{8'h00, 8'h00, 8'h01, 8'h1e, 8'h07};
        send_frame();

        set_mode(1'b0, PREFIX_2);
        frame = '{8'h00, 8'h02, 8'h65, 8'h88};
        send_frame();
        frame = '{8'h00, 8'h00};
        send_frame();
        frame = '{8'h00};
        send_frame();
        frame = '{8'h00, 8'h03, 8'h41};
        send_frame();
        frame = '{8'h00, 8'h01, 8'h41, 8'h00, 8'h01, 8'h65};
        send_frame();

        set_mode(1'b1, PREFIX_4);
        frame = '{8'h00, 8'h00, 8'h00, 8'h02, 8'h26, 8'h01};
        send_frame();
        frame = '{8'hff, 8'hff, 8'hff, 8'hff, 8'h26};
        send_frame();

        set_mode(1'b1, PREFIX_1);
        frame = '{8'h02, 8'h02, 8'h01};
        send_frame();

        set_mode(1'b0, PREFIX_BAD);
        frame = '{8'h00, 8'h02, 8'h65, 8'h88};
        send_frame();
    endtask

    // Result side; a hold-off request from the stimulus is counted out here.
    initial
    begin
        int hold;
        hold = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                sb.check_class(packet_class);
            end
            @(negedge clk);
            if (stall_req)
            begin
                stall_req = 1'b0;
                hold = HOLD_CYCLES;
            end
            if (hold > 0)
            begin
                hold--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= calm || ($urandom_range(99) >= 12);
            end
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no request accepted for %0d cycles", $time, STALL_LIMIT);
                $display("tb: FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        run_directed();
        run_phase(1'b0, PREFIX_ANNEX_B, 1'b0, 1'b0, 22);
        run_phase(1'b1, PREFIX_ANNEX_B, 1'b1, 1'b0, 22);
        run_phase(1'b0, PREFIX_1, 1'b0, 1'b0, 22);
        run_phase(1'b1, PREFIX_2, 1'b0, 1'b1, 70);
        run_phase(1'b0, PREFIX_4, 1'b0, 1'b0, 22);
        run_phase(1'b1, PREFIX_4, 1'b0, 1'b0, 22);
        run_phase(1'b1, PREFIX_BAD, 1'b0, 1'b0, 12);
        run_phase(1'b0, PREFIX_2, 1'b0, 1'b0, 22);
        run_phase(1'b1, PREFIX_1, 1'b0, 1'b0, 22);
        run_phase(1'b0, PREFIX_ANNEX_B, 1'b0, 1'b0, 22);
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge clk);
        repeat (8) @(negedge clk);
        $display("summary: %0d bytes in, %0d packets out (%0d key, %0d non-key, %0d error)",
                 bytes_sent, sb.n_key + sb.n_plain + sb.n_err, sb.n_key, sb.n_plain,
                 sb.n_err);
        $display("summary: H.264 and HEVC over start codes, 1/2/4-byte prefixes and a bad size");
        if (sb.failures == 0 && sb.pending() == 0)
        begin
            $display("tb: PASS");
        end
        else
        begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+sv
sv/nkc_pkg.sv
sv/nkc_front.sv
sv/nkc_queue.sv
sv/nkc_back.sv
sv/nal_packet_keyframe_classifier_top.sv
test/tb.sv
